// ===== hdl/des_key_schedule_macros.svh =====
// assertion helpers used by the checker file
`ifndef DES_KEY_SCHEDULE_MACROS_SVH
`define DES_KEY_SCHEDULE_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define DKS_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// condition must hold in the cycle after the trigger
`define DKS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hdl/dks_pkg.sv =====
package dks_pkg;

	localparam int HALF_W  = 28;
	localparam int CD_W    = 2 * HALF_W;
	localparam int KEY_W   = 64;
	localparam int RKEY_W  = 48;
	localparam int IDX_W   = 4;
	localparam logic [IDX_W-1:0] LAST_ROUND = 4'd15;

	// key selection that drops the parity bits, positions count from the key msb
	localparam int PC1_TAB [0:CD_W-1] = '{
		57, 49, 41, 33, 25, 17, 9,
		1, 58, 50, 42, 34, 26, 18,
		10, 2, 59, 51, 43, 35, 27,
		19, 11, 3, 60, 52, 44, 36,
		63, 55, 47, 39, 31, 23, 15,
		7, 62, 54, 46, 38, 30, 22,
		14, 6, 61, 53, 45, 37, 29,
		21, 13, 5, 28, 20, 12, 4
	};

	// subkey selection from c:d, positions count from the msb of c
	localparam int PC2_TAB [0:RKEY_W-1] = '{
		14, 17, 11, 24, 1, 5,
		3, 28, 15, 6, 21, 10,
		23, 19, 12, 4, 26, 8,
		16, 7, 27, 20, 13, 2,
		41, 52, 31, 37, 47, 55,
		30, 40, 51, 45, 33, 48,
		44, 49, 39, 56, 34, 53,
		46, 42, 50, 36, 29, 32
	};

	// set where the halves rotate by two places instead of one
	localparam logic [15:0] ROT_TWO = 16'b0111_1110_1111_1100;

	typedef logic [HALF_W-1:0] half_t;

	// round number and last flag riding with the data
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             last;
	} round_tag_t;

	function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] k);
		logic [CD_W-1:0] r;
		for (int i = 0; i < CD_W; i++) begin
			r[CD_W-1-i] = k[KEY_W-PC1_TAB[i]];
		end
		return r;
	endfunction

	function automatic logic [RKEY_W-1:0] pc2(input logic [CD_W-1:0] cd);
		logic [RKEY_W-1:0] r;
		for (int i = 0; i < RKEY_W; i++) begin
			r[RKEY_W-1-i] = cd[CD_W-PC2_TAB[i]];
		end
		return r;
	endfunction

	function automatic half_t rotl(input half_t x, input logic two);
		return two ? {x[HALF_W-3:0], x[HALF_W-1:HALF_W-2]} : {x[HALF_W-2:0], x[HALF_W-1]};
	endfunction

endpackage

// ===== hdl/dks_round_seq.sv =====
module dks_round_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     key_valid,
	output logic                     key_ready,
	input  logic [dks_pkg::KEY_W-1:0] key,
	input  logic                     nxt_ready,
	output logic                     v_s2,
	output logic [dks_pkg::CD_W-1:0] cd_s2,
	output dks_pkg::round_tag_t      tag_s2
);

	logic                        v_s1;
	logic [dks_pkg::IDX_W-1:0]   rnd_s1;
	dks_pkg::half_t              c_s1;
	dks_pkg::half_t              d_s1;
	dks_pkg::half_t              c_rot;
	dks_pkg::half_t              d_rot;
	logic                        take_s2;
	logic                        issue;
	logic                        last_issue;
	logic                        load;

	// handshake between the key holder and the rotate stage
	always_comb begin
		take_s2    = !v_s2 || nxt_ready;
		issue      = v_s1 && take_s2;
		last_issue = issue && (rnd_s1 == dks_pkg::LAST_ROUND);
		key_ready  = !v_s1 || last_issue;
		load       = key_valid && key_ready;
		c_rot      = dks_pkg::rotl(c_s1, dks_pkg::ROT_TWO[rnd_s1]);
		d_rot      = dks_pkg::rotl(d_s1, dks_pkg::ROT_TWO[rnd_s1]);
	end

	// stage 1 control: key held over sixteen rounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			rnd_s1 <= '0;
		end else if (load) begin
			v_s1   <= 1'b1;
			rnd_s1 <= '0;
		end else if (last_issue) begin
			v_s1   <= 1'b0;
		end else if (issue) begin
			rnd_s1 <= rnd_s1 + 1'b1;
		end
	end

	// stage 1 payload: halves rotate in place each round
	always_ff @(posedge clk) begin
		if (load) begin
			{c_s1, d_s1} <= dks_pkg::pc1(key);
		end else if (issue) begin
			c_s1 <= c_rot;
			d_s1 <= d_rot;
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (take_s2) begin
			v_s2 <= issue;
		end
	end

	// stage 2 payload: rotated halves and round tag
	always_ff @(posedge clk) begin
		if (issue) begin
			cd_s2       <= {c_rot, d_rot};
			tag_s2.idx  <= rnd_s1;
			tag_s2.last <= (rnd_s1 == dks_pkg::LAST_ROUND);
		end
	end

endmodule

// ===== hdl/dks_pc2_stage.sv =====
module dks_pc2_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       v_s2,
	output logic                       up_ready,
	input  logic [dks_pkg::CD_W-1:0]   cd_s2,
	input  dks_pkg::round_tag_t        tag_s2,
	output logic                       v_s3,
	input  logic                       out_ready,
	output logic [dks_pkg::RKEY_W-1:0] rkey_s3,
	output dks_pkg::round_tag_t        tag_s3
);

	assign up_ready = !v_s3 || out_ready;

	// stage 3 valid, this is the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (up_ready) begin
			v_s3 <= v_s2;
		end
	end

	// stage 3 payload: subkey selection from the rotated halves
	always_ff @(posedge clk) begin
		if (up_ready && v_s2) begin
			rkey_s3 <= dks_pkg::pc2(cd_s2);
			tag_s3  <= tag_s2;
		end
	end

endmodule

// ===== hdl/des_key_schedule.sv =====
// des key schedule: one 64-bit key in, sixteen 48-bit round keys out
// path: key registered in stage 1, rotated halves in stage 2, subkey in the stage 3 output register
// throughput: one round key per cycle while m_axis_tready is high; the next key is taken as the
//   round counter that holds the key in the first stage issues its last round
// reset: arst_n clears all valid bits and the round counter, payload is not reset
module des_key_schedule (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] des key
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [3:0] round_index, [51:4] subkey, [55:52] zero
	output logic        m_axis_tlast    // is_last
);

	logic                       v_s2;
	logic                       s2_ready;
	logic [dks_pkg::CD_W-1:0]   cd_s2;
	dks_pkg::round_tag_t        tag_s2;
	logic [dks_pkg::RKEY_W-1:0] rkey_s3;
	dks_pkg::round_tag_t        tag_s3;

	// key holder, round counter and rotation
	dks_round_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (s_axis_tvalid),
		.key_ready (s_axis_tready),
		.key       (s_axis_tdata),
		.nxt_ready (s2_ready),
		.v_s2      (v_s2),
		.cd_s2     (cd_s2),
		.tag_s2    (tag_s2)
	);

	// subkey selection and output register
	dks_pc2_stage u_pc2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s2      (v_s2),
		.up_ready  (s2_ready),
		.cd_s2     (cd_s2),
		.tag_s2    (tag_s2),
		.v_s3      (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.rkey_s3   (rkey_s3),
		.tag_s3    (tag_s3)
	);

	// pack the result beat
	assign m_axis_tdata = {4'b0000, rkey_s3, tag_s3.idx};
	assign m_axis_tlast = tag_s3.last;

endmodule

// ===== hdl/dks_checker.sv =====
`include "des_key_schedule_macros.svh"

module dks_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	logic [3:0]  exp_idx_q;
	logic        in_beat;
	logic        out_beat;
	logic        out_stall;
	logic [3:0]  out_idx;
	logic        last_idx;
	logic [56:0] out_bits;

	assign in_beat   = s_axis_tvalid && s_axis_tready;
	assign out_beat  = m_axis_tvalid && m_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_idx   = m_axis_tdata[3:0];
	assign last_idx  = (out_idx == dks_pkg::LAST_ROUND);
	assign out_bits  = {m_axis_tlast, m_axis_tdata};

	// expected round number of the next output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_beat) begin
			exp_idx_q <= exp_idx_q + 1'b1;
		end
	end

	`DKS_ASSERT_NEXT(a_hold, out_stall, m_axis_tvalid && $stable(out_bits), "beat changed in stall")
	`DKS_ASSERT_SAME(a_order, m_axis_tvalid, out_idx == exp_idx_q, "round keys out of order")
	`DKS_ASSERT_SAME(a_last, m_axis_tvalid, m_axis_tlast == last_idx, "last flag misplaced")
	`DKS_ASSERT_NEXT(a_busy, in_beat, !s_axis_tready, "key taken while rounds pending")
	`DKS_ASSERT_SAME(a_pad, m_axis_tvalid, m_axis_tdata[55:52] == 4'b0000, "padding not zero")

endmodule

bind des_key_schedule dks_checker u_dks_checker (.*);
